/* rtl/tmcps_pkg.sv */
`timescale 1ns / 1ps

package tmcps_pkg;

    localparam int TILE_SIZE_DEF = 5;
    localparam int MAX_DIM_DEF   = 4096;

    localparam int DIM_W  = 13;
    localparam int COST_W = 16;
    localparam int POS_W  = 12;
    localparam int CFG_W  = 16;
    localparam int IDX_W  = 2;

    localparam logic [DIM_W-1:0]  WIDTH_RST     = 13'd640;
    localparam logic [DIM_W-1:0]  HEIGHT_RST    = 13'd480;
    localparam logic [COST_W-1:0] CEILING_RST   = 16'd32768;
    localparam logic [COST_W-1:0] THRESHOLD_RST = 16'd1639;

    typedef enum logic [IDX_W-1:0] {
        CFG_IMAGE_WIDTH      = 2'd0,
        CFG_IMAGE_HEIGHT     = 2'd1,
        CFG_COST_CEILING     = 2'd2,
        CFG_ACCEPT_THRESHOLD = 2'd3
    } cfg_index_t;

    // Per-pixel control and payload handed from the position sequencer
    typedef struct packed {
        logic              first;
        logic              last;
        logic [COST_W-1:0] cost;
        logic [POS_W-1:0]  x;
        logic [POS_W-1:0]  y;
    } pixel_info_t;

    // One tile row entry of the state memory
    typedef struct packed {
        logic              has_point;
        logic [COST_W-1:0] cost;
        logic [POS_W-1:0]  x;
        logic [POS_W-1:0]  y;
    } tile_entry_t;

endpackage

/* rtl/tile_min_cost_point_select_top.sv */
`timescale 1ns / 1ps

// Tile minimum-cost point selector.
// Input channel (s_valid/s_ready/s_pixel_cost): one Q2.14 cost per pixel in
// column-major order. Output channel (m_valid/m_ready/m_point_x/m_point_y):
// at most one point per tile, sent when the tile's last pixel has been taken
// and its lowest accepted cost lies below the accept threshold.
// Configuration: cfg_wr_en/cfg_index/cfg_wr_data write one register per
// cycle; write only while no transaction is in flight.
// Throughput: one pixel per cycle unless a pending point stalls the input. The
// tile state lives in one memory addressed by tile row, read at accept and
// written back as the pixel leaves the p1 stage; the last write is forwarded
// when the next pixel hits the same tile row. A point passes the p1 stage and
// then the output register before it appears on m_valid. While the receiver
// stalls, pixels that produce no point keep flowing; a second pending point
// holds s_ready low until the output register frees up.
// Reset: registers return to their defaults and the pixel position to
// column 0, row 0. The memory needs no clearing since each entry is
// written at the first pixel of its tile.

module tile_min_cost_point_select_top
    import tmcps_pkg::*;
#(
    parameter int TILE_SIZE = TILE_SIZE_DEF,
    parameter int MAX_DIM   = MAX_DIM_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [COST_W-1:0] s_pixel_cost,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [POS_W-1:0]  m_point_x,
    output logic [POS_W-1:0]  m_point_y,
    input  logic              cfg_wr_en,
    input  logic [IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]  cfg_wr_data
);

    localparam int TILE_ROWS = (MAX_DIM + TILE_SIZE - 1) / TILE_SIZE;
    localparam int TR_W      = (TILE_ROWS > 1) ? $clog2(TILE_ROWS) : 1;

    logic [DIM_W-1:0]  width_reg, height_reg, width_eff, height_eff;
    logic [COST_W-1:0] ceiling_reg, threshold_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg     <= WIDTH_RST;
            height_reg    <= HEIGHT_RST;
            ceiling_reg   <= CEILING_RST;
            threshold_reg <= THRESHOLD_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_IMAGE_WIDTH:      width_reg     <= cfg_wr_data[DIM_W-1:0];
                CFG_IMAGE_HEIGHT:     height_reg    <= cfg_wr_data[DIM_W-1:0];
                CFG_COST_CEILING:     ceiling_reg   <= cfg_wr_data;
                CFG_ACCEPT_THRESHOLD: threshold_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // Zero reads as one, anything above the maximum clamps to it
    always_comb begin
        width_eff = width_reg;
        if (width_reg == '0) begin
            width_eff = DIM_W'(1);
        end else if (width_reg > DIM_W'(MAX_DIM)) begin
            width_eff = DIM_W'(MAX_DIM);
        end
        height_eff = height_reg;
        if (height_reg == '0) begin
            height_eff = DIM_W'(1);
        end else if (height_reg > DIM_W'(MAX_DIM)) begin
            height_eff = DIM_W'(MAX_DIM);
        end
    end

    logic            accept, advance, busy, emit;
    logic [TR_W-1:0] tile_row;
    pixel_info_t     info;
    logic [POS_W-1:0] emit_x, emit_y;

    logic             m_valid_reg, m_valid_next;
    logic [POS_W-1:0] m_x_reg, m_y_reg;

    assign advance = !emit || !m_valid_reg || m_ready;
    assign s_ready = !busy || advance;
    assign accept  = s_valid && s_ready;

    tmcps_position #(
        .TILE_SIZE (TILE_SIZE),
        .MAX_DIM   (MAX_DIM)
    ) u_position (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .width      (width_eff),
        .height     (height_eff),
        .pixel_cost (s_pixel_cost),
        .tile_row   (tile_row),
        .info       (info)
    );

    tmcps_tile_store #(
        .TILE_SIZE (TILE_SIZE),
        .MAX_DIM   (MAX_DIM)
    ) u_tile_store (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .rd_en            (accept),
        .rd_addr          (tile_row),
        .rd_info          (info),
        .advance          (advance),
        .cost_ceiling     (ceiling_reg),
        .accept_threshold (threshold_reg),
        .busy             (busy),
        .emit             (emit),
        .emit_x           (emit_x),
        .emit_y           (emit_y)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (emit && advance) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // Load a point only when the previous transaction is done
    always_ff @(posedge aclk) begin
        if (emit && advance) begin
            m_x_reg <= emit_x;
            m_y_reg <= emit_y;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_point_x = m_x_reg;
    assign m_point_y = m_y_reg;

endmodule

/* rtl/tmcps_position.sv */
`timescale 1ns / 1ps

module tmcps_position
    import tmcps_pkg::*;
#(
    parameter int TILE_SIZE = TILE_SIZE_DEF,
    parameter int MAX_DIM   = MAX_DIM_DEF,
    localparam int TILE_ROWS = (MAX_DIM + TILE_SIZE - 1) / TILE_SIZE,
    localparam int TR_W      = (TILE_ROWS > 1) ? $clog2(TILE_ROWS) : 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              accept,
    input  logic [DIM_W-1:0]  width,
    input  logic [DIM_W-1:0]  height,
    input  logic [COST_W-1:0] pixel_cost,
    output logic [TR_W-1:0]   tile_row,
    output pixel_info_t       info
);

    localparam int CNT_W = $clog2(MAX_DIM);
    localparam int RY_W  = $clog2(TILE_SIZE);

    logic [CNT_W-1:0] row_reg, row_next, col_reg, col_next;
    logic [RY_W-1:0]  ry_reg, ry_next, cit_reg, cit_next;
    logic [TR_W-1:0]  t_reg, t_next;

    logic [CNT_W-1:0] row_e, col_e;
    logic [RY_W-1:0]  ry_e, cit_e;
    logic [TR_W-1:0]  t_e;
    logic [DIM_W-1:0] row_p1, col_p1;
    logic [RY_W:0]    cit_p1;

    // Restart counters that fall outside a newly written size
    always_comb begin
        row_e = row_reg;
        ry_e  = ry_reg;
        t_e   = t_reg;
        col_e = col_reg;
        cit_e = cit_reg;
        if (DIM_W'(row_reg) >= height) begin
            row_e = '0;
            ry_e  = '0;
            t_e   = '0;
        end
        if (DIM_W'(col_reg) >= width) begin
            col_e = '0;
            cit_e = '0;
        end
    end

    assign row_p1 = DIM_W'(row_e) + DIM_W'(1);
    assign col_p1 = DIM_W'(col_e) + DIM_W'(1);
    assign cit_p1 = (RY_W+1)'(cit_e) + (RY_W+1)'(1);

    always_comb begin
        row_next = row_e;
        ry_next  = ry_e;
        t_next   = t_e;
        col_next = col_e;
        cit_next = cit_e;
        if (row_p1 >= height) begin
            row_next = '0;
            ry_next  = '0;
            t_next   = '0;
            col_next = (col_p1 >= width) ? '0 : col_p1[CNT_W-1:0];
            cit_next = (cit_p1 >= (RY_W+1)'(TILE_SIZE) || col_p1 >= width) ?
                       '0 : cit_p1[RY_W-1:0];
        end else begin
            row_next = row_p1[CNT_W-1:0];
            if (ry_e == RY_W'(TILE_SIZE - 1)) begin
                ry_next = '0;
                t_next  = t_e + TR_W'(1);
            end else begin
                ry_next = ry_e + RY_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg <= '0;
            col_reg <= '0;
            ry_reg  <= '0;
            cit_reg <= '0;
            t_reg   <= '0;
        end else if (accept) begin
            row_reg <= row_next;
            col_reg <= col_next;
            ry_reg  <= ry_next;
            cit_reg <= cit_next;
            t_reg   <= t_next;
        end
    end

    assign tile_row   = t_e;
    assign info.first = (cit_e == '0) && (ry_e == '0);
    assign info.last  = ((cit_e == RY_W'(TILE_SIZE - 1)) || (col_p1 == width)) &&
                        ((ry_e == RY_W'(TILE_SIZE - 1)) || (row_p1 == height));
    assign info.cost  = pixel_cost;
    assign info.x     = POS_W'(col_e);
    assign info.y     = POS_W'(row_e);

endmodule

/* rtl/tmcps_tile_store.sv */
`timescale 1ns / 1ps

module tmcps_tile_store
    import tmcps_pkg::*;
#(
    parameter int TILE_SIZE = TILE_SIZE_DEF,
    parameter int MAX_DIM   = MAX_DIM_DEF,
    localparam int TILE_ROWS = (MAX_DIM + TILE_SIZE - 1) / TILE_SIZE,
    localparam int TR_W      = (TILE_ROWS > 1) ? $clog2(TILE_ROWS) : 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              rd_en,
    input  logic [TR_W-1:0]   rd_addr,
    input  pixel_info_t       rd_info,
    input  logic              advance,
    input  logic [COST_W-1:0] cost_ceiling,
    input  logic [COST_W-1:0] accept_threshold,
    output logic              busy,
    output logic              emit,
    output logic [POS_W-1:0]  emit_x,
    output logic [POS_W-1:0]  emit_y
);

    tile_entry_t mem [TILE_ROWS];
    tile_entry_t rd_data_reg;

    logic        p1_valid_reg, p1_valid_next;
    logic [TR_W-1:0] p1_addr_reg;
    pixel_info_t p1_info_reg;

    logic        fwd_valid_reg;
    logic [TR_W-1:0] fwd_addr_reg;
    tile_entry_t fwd_data_reg;

    tile_entry_t base, updated;
    logic        wr_en;

    assign wr_en = p1_valid_reg && advance;

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
        if (wr_en) begin
            mem[p1_addr_reg] <= updated;
        end
    end

    // Current entry: fresh at a tile's first pixel, else the last write or memory
    always_comb begin
        priority if (p1_info_reg.first) begin
            base.has_point = 1'b0;
            base.cost      = cost_ceiling;
            base.x         = p1_info_reg.x;
            base.y         = p1_info_reg.y;
        end else if (fwd_valid_reg && fwd_addr_reg == p1_addr_reg) begin
            base = fwd_data_reg;
        end else begin
            base = rd_data_reg;
        end
        updated = base;
        if (p1_info_reg.cost < cost_ceiling && p1_info_reg.cost < base.cost) begin
            updated.has_point = 1'b1;
            updated.cost      = p1_info_reg.cost;
            updated.x         = p1_info_reg.x;
            updated.y         = p1_info_reg.y;
        end
    end

    assign emit   = p1_valid_reg && p1_info_reg.last && updated.has_point &&
                    (updated.cost < accept_threshold);
    assign emit_x = updated.x;
    assign emit_y = updated.y;
    assign busy   = p1_valid_reg;

    always_comb begin
        p1_valid_next = p1_valid_reg;
        if (rd_en) begin
            p1_valid_next = 1'b1;
        end else if (advance) begin
            p1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end else begin
            p1_valid_reg <= p1_valid_next;
            if (wr_en) begin
                fwd_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            p1_addr_reg <= rd_addr;
            p1_info_reg <= rd_info;
        end
        if (wr_en) begin
            fwd_addr_reg <= p1_addr_reg;
            fwd_data_reg <= updated;
        end
    end

endmodule
